// ===== hw/rtl/igt_pkg.sv =====
// Package for the indexed graph table: operation and status codes, and the
// command and status structs that join the controller and the datapath.
// No dependencies.
`timescale 1ns / 1ps

package igt_pkg;

  // Operation codes of an input item.
  localparam logic [2:0] OP_APPEND  = 3'd0;
  localparam logic [2:0] OP_INSERT  = 3'd1;
  localparam logic [2:0] OP_REMOVE  = 3'd2;
  localparam logic [2:0] OP_CONNECT = 3'd3;
  localparam logic [2:0] OP_READ    = 3'd4;

  // Status codes of a result item.
  localparam logic [2:0] ST_OK      = 3'd0;
  localparam logic [2:0] ST_FULL    = 3'd1;
  localparam logic [2:0] ST_NOKEY   = 3'd2;
  localparam logic [2:0] ST_BADPOS  = 3'd3;
  localparam logic [2:0] ST_DEGFULL = 3'd4;

  // Source of the slot-map read address that addresses the node memory.
  typedef enum logic [1:0] {MS_I, MS_POS, MS_NB, MS_A} map_sel_t;

  // Adjacency memory write kinds.
  typedef enum logic [1:0] {AW_NONE, AW_INS, AW_RM, AW_CON} adj_wr_t;

  // Node memory write kinds.
  typedef enum logic [1:0] {NW_NONE, NW_NEW, NW_DEG, NW_INC} node_wr_t;

  // Slot-map updates.
  typedef enum logic [1:0] {MO_NONE, MO_INS, MO_REM} map_op_t;

  // Output register loads.
  typedef enum logic [1:0] {OL_NONE, OL_STAT, OL_NODE, OL_NB} out_ld_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic     capture;
    logic     i_clr;
    logic     i_inc;
    logic     j_clr;
    logic     j_inc;
    logic     phys_ld;
    logic     rec_ld;
    logic     fa_ld;
    logic     fb_ld;
    logic     st_set;
    logic [2:0] st_code;
    map_sel_t map_sel;
    adj_wr_t  adj_wr;
    node_wr_t node_wr;
    map_op_t  map_op;
    logic     cnt_inc;
    logic     cnt_dec;
    out_ld_t  out_ld;
    logic     out_last;
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic [2:0] op;
    logic       full;
    logic       bad_ins;
    logic       bad_rd;
    logic       i_end;
    logic       hit_a;
    logic       hit_b;
    logic       q_deg_zero;
    logic       q_deg_full;
    logic       j_last;
    logic       out_busy;
  } stat_t;

endpackage

// ===== hw/rtl/igt_ctrl.sv =====
// Controller of the indexed graph table: a one-hot state machine that
// sequences lookups, adjacency sweeps, table updates and result emission.
// Depends on igt_pkg.
`timescale 1ns / 1ps

module igt_ctrl import igt_pkg::*; (
  input  logic  clk,
  input  logic  rst,
  input  logic  in_valid,
  output logic  in_ready,
  input  stat_t st,
  output cmd_t  cmd
);

  typedef enum logic [22:0] {
    S_IDLE  = 23'h000001,
    S_DISP  = 23'h000002,
    S_FA    = 23'h000004,
    S_FAQ   = 23'h000008,
    S_FB    = 23'h000010,
    S_FBQ   = 23'h000020,
    S_RMSH  = 23'h000040,
    S_ROW   = 23'h000080,
    S_ROWQ  = 23'h000100,
    S_ARD   = 23'h000200,
    S_AWR   = 23'h000400,
    S_ROWWR = 23'h000800,
    S_PUT   = 23'h001000,
    S_CREC  = 23'h002000,
    S_CCHK  = 23'h004000,
    S_CWR   = 23'h008000,
    S_RREC  = 23'h010000,
    S_RRECQ = 23'h020000,
    S_RADJ  = 23'h040000,
    S_RNB   = 23'h080000,
    S_RNK   = 23'h100000,
    S_EMIT  = 23'h200000,
    S_EMITN = 23'h400000
  } state_t;

  state_t state, state_next;

  // State register.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  assign in_ready = (state == S_IDLE);

  // Next state and commands.
  always_comb begin
    state_next = state;
    cmd = '0;
    case (state)
      S_IDLE: begin
        if (in_valid) begin
          cmd.capture = 1'b1;
          state_next = S_DISP;
        end
      end
      S_DISP: begin
        case (st.op)
          OP_APPEND: begin
            if (st.full) begin
              cmd.st_set = 1'b1;
              cmd.st_code = ST_FULL;
              state_next = S_EMIT;
            end else begin
              state_next = S_PUT;
            end
          end
          OP_INSERT: begin
            if (st.full) begin
              cmd.st_set = 1'b1;
              cmd.st_code = ST_FULL;
              state_next = S_EMIT;
            end else if (st.bad_ins) begin
              cmd.st_set = 1'b1;
              cmd.st_code = ST_BADPOS;
              state_next = S_EMIT;
            end else begin
              cmd.i_clr = 1'b1;
              state_next = S_ROW;
            end
          end
          OP_REMOVE, OP_CONNECT: begin
            cmd.i_clr = 1'b1;
            state_next = S_FA;
          end
          OP_READ: begin
            if (st.bad_rd) begin
              cmd.st_set = 1'b1;
              cmd.st_code = ST_BADPOS;
              state_next = S_EMIT;
            end else begin
              state_next = S_RREC;
            end
          end
          default: state_next = S_EMIT;
        endcase
      end
      // Linear search for key A.
      S_FA: begin
        cmd.map_sel = MS_I;
        if (st.i_end) begin
          cmd.st_set = 1'b1;
          cmd.st_code = ST_NOKEY;
          state_next = S_EMIT;
        end else begin
          state_next = S_FAQ;
        end
      end
      S_FAQ: begin
        cmd.map_sel = MS_I;
        if (st.hit_a) begin
          cmd.fa_ld = 1'b1;
          if (st.op == OP_REMOVE) begin
            state_next = S_RMSH;
          end else begin
            cmd.i_clr = 1'b1;
            state_next = S_FB;
          end
        end else begin
          cmd.i_inc = 1'b1;
          state_next = S_FA;
        end
      end
      // Linear search for key B.
      S_FB: begin
        cmd.map_sel = MS_I;
        if (st.i_end) begin
          cmd.st_set = 1'b1;
          cmd.st_code = ST_NOKEY;
          state_next = S_EMIT;
        end else begin
          state_next = S_FBQ;
        end
      end
      S_FBQ: begin
        cmd.map_sel = MS_I;
        if (st.hit_b) begin
          cmd.fb_ld = 1'b1;
          state_next = S_CREC;
        end else begin
          cmd.i_inc = 1'b1;
          state_next = S_FB;
        end
      end
      // Drop the node from the slot map, then renumber the rest.
      S_RMSH: begin
        cmd.map_op = MO_REM;
        cmd.cnt_dec = 1'b1;
        cmd.i_clr = 1'b1;
        state_next = S_ROW;
      end
      // Adjacency sweep over every row in use.
      S_ROW: begin
        cmd.map_sel = MS_I;
        cmd.phys_ld = 1'b1;
        if (st.i_end) begin
          state_next = (st.op == OP_INSERT) ? S_PUT : S_EMIT;
        end else begin
          state_next = S_ROWQ;
        end
      end
      S_ROWQ: begin
        cmd.rec_ld = 1'b1;
        cmd.j_clr = 1'b1;
        if (st.q_deg_zero) begin
          cmd.i_inc = 1'b1;
          state_next = S_ROW;
        end else begin
          state_next = S_ARD;
        end
      end
      S_ARD: state_next = S_AWR;
      S_AWR: begin
        cmd.adj_wr = (st.op == OP_INSERT) ? AW_INS : AW_RM;
        cmd.j_inc = 1'b1;
        if (!st.j_last) begin
          state_next = S_ARD;
        end else if (st.op == OP_INSERT) begin
          cmd.i_inc = 1'b1;
          state_next = S_ROW;
        end else begin
          state_next = S_ROWWR;
        end
      end
      S_ROWWR: begin
        cmd.node_wr = NW_DEG;
        cmd.i_inc = 1'b1;
        state_next = S_ROW;
      end
      // Write the new node and grow the table.
      S_PUT: begin
        cmd.node_wr = NW_NEW;
        cmd.map_op = (st.op == OP_INSERT) ? MO_INS : MO_NONE;
        cmd.cnt_inc = 1'b1;
        state_next = S_EMIT;
      end
      // Add an edge to the source row.
      S_CREC: begin
        cmd.map_sel = MS_A;
        cmd.phys_ld = 1'b1;
        state_next = S_CCHK;
      end
      S_CCHK: begin
        cmd.rec_ld = 1'b1;
        if (st.q_deg_full) begin
          cmd.st_set = 1'b1;
          cmd.st_code = ST_DEGFULL;
          state_next = S_EMIT;
        end else begin
          state_next = S_CWR;
        end
      end
      S_CWR: begin
        cmd.adj_wr = AW_CON;
        cmd.node_wr = NW_INC;
        state_next = S_EMIT;
      end
      // Read a node and walk its neighbor list.
      S_RREC: begin
        cmd.map_sel = MS_POS;
        cmd.phys_ld = 1'b1;
        state_next = S_RRECQ;
      end
      S_RRECQ: begin
        cmd.rec_ld = 1'b1;
        cmd.j_clr = 1'b1;
        state_next = st.q_deg_zero ? S_EMITN : S_RADJ;
      end
      S_RADJ: state_next = S_RNB;
      S_RNB: begin
        cmd.map_sel = MS_NB;
        state_next = S_RNK;
      end
      S_RNK: begin
        cmd.map_sel = MS_NB;
        if (!st.out_busy) begin
          cmd.out_ld = OL_NB;
          cmd.out_last = st.j_last;
          cmd.j_inc = 1'b1;
          state_next = st.j_last ? S_IDLE : S_RADJ;
        end
      end
      S_EMIT: begin
        if (!st.out_busy) begin
          cmd.out_ld = OL_STAT;
          cmd.out_last = 1'b1;
          state_next = S_IDLE;
        end
      end
      S_EMITN: begin
        if (!st.out_busy) begin
          cmd.out_ld = OL_NODE;
          cmd.out_last = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

endmodule

// ===== hw/rtl/igt_dpath.sv =====
// Datapath of the indexed graph table: input capture, slot map, node and
// adjacency memories, loop counters and the output register.
// Depends on igt_pkg.
`timescale 1ns / 1ps

module igt_dpath import igt_pkg::*; #(
  parameter int MAX_NODES  = 16,
  parameter int MAX_DEGREE = 16,
  parameter int KEY_BITS   = 16
) (
  input  logic        clk,
  input  logic        rst,
  input  logic [71:0] in_data,
  input  logic [4:0]  node_limit,
  input  cmd_t        cmd,
  output stat_t       st,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [71:0] out_data,
  output logic        out_user,
  output logic        out_last
);

  localparam int IW  = $clog2(MAX_NODES);
  localparam int CW  = $clog2(MAX_NODES + 1);
  localparam int DGW = $clog2(MAX_DEGREE + 1);
  localparam int JW  = (MAX_DEGREE > 1) ? $clog2(MAX_DEGREE) : 1;
  localparam int ADEPTH = MAX_NODES * (2 ** JW);

  typedef struct packed {
    logic [KEY_BITS-1:0] key;
    logic [15:0]         x;
    logic [15:0]         y;
    logic [DGW-1:0]      deg;
  } rec_t;

  // Captured input item.
  logic [2:0]          op_r;
  logic [KEY_BITS-1:0] ka;
  logic [KEY_BITS-1:0] kb;
  logic [15:0]         px;
  logic [15:0]         py;
  logic [4:0]          pos_r;
  logic [2:0]          status_r;

  // Table control state.
  logic [CW-1:0]  count;
  logic [IW-1:0]  slot_map [MAX_NODES];
  logic [CW-1:0]  i;
  logic [DGW-1:0] j;
  logic [DGW-1:0] keep;
  logic [IW-1:0]  phys;
  logic [IW-1:0]  idx_a;
  logic [IW-1:0]  idx_b;
  rec_t           rec;

  // Memories.
  rec_t          node_mem [MAX_NODES];
  logic [IW-1:0] adj_mem  [ADEPTH];
  rec_t          node_q;
  logic [IW-1:0] adj_q;

  logic [IW-1:0] map_ra;
  logic [IW-1:0] node_ra;
  logic [IW+JW-1:0] adj_ra;
  logic [31:0]   cap;

  // Output item being assembled.
  logic [71:0]   out_data_next;
  logic          out_user_next;

  // Capture of the input item and the status code.
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      op_r  <= in_data[2:0];
      ka    <= KEY_BITS'(in_data[18:3]);
      kb    <= KEY_BITS'(in_data[34:19]);
      px    <= in_data[50:35];
      py    <= in_data[66:51];
      pos_r <= in_data[71:67];
    end
    if (cmd.capture) begin
      status_r <= ST_OK;
    end else if (cmd.st_set) begin
      status_r <= cmd.st_code;
    end
  end

  // Slot map read port.
  always_comb begin
    case (cmd.map_sel)
      MS_I:    map_ra = IW'(i);
      MS_POS:  map_ra = IW'(pos_r);
      MS_NB:   map_ra = adj_q;
      MS_A:    map_ra = idx_a;
      default: map_ra = IW'(i);
    endcase
    node_ra = slot_map[map_ra];
    adj_ra  = {phys, JW'(j)};
  end

  // Slot map, node count and loop registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
      i     <= '0;
      j     <= '0;
      keep  <= '0;
      for (int k = 0; k < MAX_NODES; k++) begin
        slot_map[k] <= IW'(k);
      end
    end else begin
      if (cmd.cnt_inc) count <= count + 1'b1;
      if (cmd.cnt_dec) count <= count - 1'b1;
      if (cmd.i_clr) i <= '0;
      else if (cmd.i_inc) i <= i + 1'b1;
      if (cmd.j_clr) j <= '0;
      else if (cmd.j_inc) j <= j + 1'b1;
      if (cmd.j_clr) keep <= '0;
      else if (cmd.adj_wr == AW_RM && adj_q != idx_a) keep <= keep + 1'b1;
      // Rotate the map so logical order follows the table.
      for (int k = 0; k < MAX_NODES; k++) begin
        if (cmd.map_op == MO_INS) begin
          if (k == int'(pos_r)) slot_map[k] <= slot_map[IW'(count)];
          else if (k > int'(pos_r) && k <= int'(count)) slot_map[k] <= slot_map[k-1];
        end else if (cmd.map_op == MO_REM) begin
          if (k == int'(count) - 1) slot_map[k] <= slot_map[idx_a];
          else if (k >= int'(idx_a) && k < int'(count) - 1) slot_map[k] <= slot_map[k+1];
        end
      end
    end
  end

  // Working registers of the current row.
  always_ff @(posedge clk) begin
    if (cmd.phys_ld) phys <= node_ra;
    if (cmd.rec_ld) rec <= node_q;
    if (cmd.fa_ld) idx_a <= IW'(i);
    if (cmd.fb_ld) idx_b <= IW'(i);
  end

  // Node memory: one write port, one registered read port.
  always_ff @(posedge clk) begin
    case (cmd.node_wr)
      NW_NEW: node_mem[slot_map[IW'(count)]] <= '{key: ka, x: px, y: py, deg: '0};
      NW_DEG: node_mem[phys] <= '{key: rec.key, x: rec.x, y: rec.y, deg: keep};
      NW_INC: node_mem[phys] <= '{key: rec.key, x: rec.x, y: rec.y, deg: rec.deg + 1'b1};
      default: ;
    endcase
    node_q <= node_mem[node_ra];
  end

  // Adjacency memory: one write port, one registered read port.
  always_ff @(posedge clk) begin
    case (cmd.adj_wr)
      AW_INS: adj_mem[adj_ra] <= (adj_q >= IW'(pos_r)) ? adj_q + 1'b1 : adj_q;
      AW_RM: begin
        if (adj_q != idx_a) begin
          adj_mem[{phys, JW'(keep)}] <= (adj_q > idx_a) ? adj_q - 1'b1 : adj_q;
        end
      end
      AW_CON: adj_mem[{phys, JW'(rec.deg)}] <= idx_b;
      default: ;
    endcase
    adj_q <= adj_mem[adj_ra];
  end

  // Status toward the controller.
  always_comb begin
    if (node_limit == 5'd0) cap = 32'd1;
    else if (32'(node_limit) > 32'(MAX_NODES)) cap = 32'(MAX_NODES);
    else cap = 32'(node_limit);
    st.op         = op_r;
    st.full       = 32'(count) >= cap;
    st.bad_ins    = 32'(pos_r) > 32'(count);
    st.bad_rd     = 32'(pos_r) >= 32'(count);
    st.i_end      = i >= count;
    st.hit_a      = node_q.key == ka;
    st.hit_b      = node_q.key == kb;
    st.q_deg_zero = node_q.deg == '0;
    st.q_deg_full = node_q.deg >= DGW'(MAX_DEGREE);
    st.j_last     = j == rec.deg - 1'b1;
    st.out_busy   = out_valid && !out_ready;
  end

  // Output item assembly.
  always_comb begin
    out_data_next = '0;
    out_user_next = 1'b0;
    case (cmd.out_ld)
      OL_STAT: out_data_next[2:0] = status_r;
      OL_NODE: begin
        out_data_next[2:0]   = ST_OK;
        out_data_next[18:3]  = 16'(rec.key);
        out_data_next[34:19] = rec.x;
        out_data_next[50:35] = rec.y;
      end
      OL_NB: begin
        out_data_next[2:0]   = ST_OK;
        out_data_next[18:3]  = 16'(rec.key);
        out_data_next[34:19] = rec.x;
        out_data_next[50:35] = rec.y;
        out_data_next[54:51] = 4'(adj_q);
        out_data_next[70:55] = 16'(node_q.key);
        out_user_next        = 1'b1;
      end
      default: ;
    endcase
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.out_ld != OL_NONE) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
    if (cmd.out_ld != OL_NONE) begin
      out_data <= out_data_next;
      out_user <= out_user_next;
      out_last <= cmd.out_last;
    end
  end

endmodule

// ===== hw/rtl/indexed_graph_table_core.sv =====
// Indexed graph table top level: stream ports, capacity register, and the
// controller and datapath. Depends on igt_pkg, igt_ctrl and igt_dpath.
// One item at a time. Remove and insert sweep the stored edges of every row
// in use, and remove and connect look up their keys by linear search. Reset
// (rst, synchronous) empties the table, sets capacity to 16 and drops any
// pending result; no clearing pass.
`timescale 1ns / 1ps

module indexed_graph_table_core import igt_pkg::*; #(
  parameter int MAX_NODES  = 16,
  parameter int MAX_DEGREE = 16,
  parameter int KEY_BITS   = 16
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  // op[2:0], key_a[18:3], key_b[34:19], pos_x[50:35], pos_y[66:51],
  // position[71:67]
  input  logic [71:0] s_tdata,
  output logic        m_tvalid,
  input  logic        m_tready,
  // status[2:0], node_key[18:3], node_x[34:19], node_y[50:35],
  // neighbor_index[54:51], neighbor_key[70:55], zero pad[71]
  output logic [71:0] m_tdata,
  // neighbor_valid[0]
  output logic        m_tuser,
  output logic        m_tlast,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [4:0]  cfg_data
);

  logic [4:0] node_limit;
  cmd_t       cmd;
  stat_t      st;

  // Capacity register.
  assign cfg_ready = 1'b1;
  always_ff @(posedge clk) begin
    if (rst) begin
      node_limit <= 5'd16;
    end else if (cfg_valid) begin
      node_limit <= cfg_data;
    end
  end

  igt_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s_tvalid),
    .in_ready (s_tready),
    .st       (st),
    .cmd      (cmd)
  );

  igt_dpath #(
    .MAX_NODES  (MAX_NODES),
    .MAX_DEGREE (MAX_DEGREE),
    .KEY_BITS   (KEY_BITS)
  ) u_dpath (
    .clk        (clk),
    .rst        (rst),
    .in_data    (s_tdata),
    .node_limit (node_limit),
    .cmd        (cmd),
    .st         (st),
    .out_valid  (m_tvalid),
    .out_ready  (m_tready),
    .out_data   (m_tdata),
    .out_user   (m_tuser),
    .out_last   (m_tlast)
  );

endmodule
